// File: hw/rtl/mch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants for magnetometer calibration/heading
// Payload structs, gain table, CORDIC arctangent table, config indexes.
// ----------------------------------------------------------------------------
package mch_pkg;

  localparam int AngleIterations = 16;
  localparam int IterW = 5;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_DECL = 2'd1;
  localparam logic [1:0] REG_CALN = 2'd2;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [19:0] field_x;
    logic signed [19:0] field_y;
    logic signed [19:0] field_z;
    logic        [15:0] heading_centideg;
    logic               degenerate_axis;
  } out_item_t;

  // front to back: classified job
  typedef struct packed {
    logic               calib;  // 1: finish calibration, 0: measure
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic        [10:0] gain;
  } job_t;

  function automatic logic [10:0] gain_q8(input logic [2:0] c);
    case (c)
      3'd0: gain_q8 = 11'd187;
      3'd1: gain_q8 = 11'd236;
      3'd2: gain_q8 = 11'd312;
      3'd3: gain_q8 = 11'd389;
      3'd4: gain_q8 = 11'd581;
      3'd5: gain_q8 = 11'd655;
      3'd6: gain_q8 = 11'd776;
      default: gain_q8 = 11'd1114;
    endcase
  endfunction

  function automatic logic [28:0] atan_tab(input logic [IterW-1:0] i);
    case (i)
      5'd0: atan_tab = 29'd294912000;
      5'd1: atan_tab = 29'd174096719;
      5'd2: atan_tab = 29'd91987925;
      5'd3: atan_tab = 29'd46694507;
      5'd4: atan_tab = 29'd23437865;
      5'd5: atan_tab = 29'd11730358;
      5'd6: atan_tab = 29'd5866610;
      5'd7: atan_tab = 29'd2933484;
      5'd8: atan_tab = 29'd1466765;
      5'd9: atan_tab = 29'd733385;
      5'd10: atan_tab = 29'd366693;
      5'd11: atan_tab = 29'd183347;
      5'd12: atan_tab = 29'd91673;
      5'd13: atan_tab = 29'd45837;
      5'd14: atan_tab = 29'd22918;
      5'd15: atan_tab = 29'd11459;
      5'd16: atan_tab = 29'd5730;
      5'd17: atan_tab = 29'd2865;
      5'd18: atan_tab = 29'd1432;
      5'd19: atan_tab = 29'd716;
      5'd20: atan_tab = 29'd358;
      5'd21: atan_tab = 29'd179;
      5'd22: atan_tab = 29'd90;
      default: atan_tab = 29'd45;
    endcase
  endfunction

  typedef enum logic [3:0] {
    BK_IDLE, BK_CAL_SUM, BK_CAL_TOT, BK_CAL_SET, BK_CAL_DIV, BK_CAL_SCL, BK_CAL_DONE,
    BK_MUL1, BK_MUL2, BK_SAT, BK_VEC_INIT, BK_CORDIC, BK_HDG, BK_MOD, BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/magnetometer_calibrate_heading.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_calibrate_heading: top level
// Front part accepts and calibrates min/max; back part does the arithmetic.
//
//   channel  signals                          transfer at
//   input    in_valid, in_stall, in_data      in_valid && !in_stall
//   output   out_valid, out_stall, out_data   out_valid && !out_stall
//   config   cfg_we, cfg_index, cfg_data      cfg_we
//
// Calibration samples before the last give no result; the front takes one
// per cycle until its two-entry job queue is full.
// A measurement runs the three axis products (multiply, multiply, saturate
// per axis), 16 CORDIC steps and the heading wrap; a zero x/y vector skips CORDIC.
// The last calibration sample runs three 33-step divisions, one per axis.
// A stalled result holds the back; the queue then fills and stalls the input.
// rst is synchronous and empties the queue and the back.
// ----------------------------------------------------------------------------
module magnetometer_calibrate_heading (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mch_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mch_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import mch_pkg::*;
  logic [2:0] gain_code;
  logic signed [15:0] decl;
  logic [15:0] caln;
  logic jv, jt;
  job_t j;
  logic signed [15:0] mn [3];
  logic signed [15:0] mx [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_code <= 3'd1; decl <= '0; caln <= 16'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN: gain_code <= cfg_data[2:0];
        REG_DECL: decl <= cfg_data;
        REG_CALN: caln <= cfg_data;
        default: ;
      endcase
    end
  end

  mch_front u_front (.clk, .rst, .in_valid, .in_stall, .in_data, .gain_code,
    .calib_samples(caln), .job_valid(jv), .job_take(jt), .job(j), .mn, .mx);
  mch_back u_back (.clk, .rst, .job_valid(jv), .job_take(jt), .job(j), .mn, .mx,
    .declination_centideg(decl), .out_valid, .out_stall, .out_data);
endmodule
`default_nettype wire

// File: hw/rtl/mch_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mch_front: input acceptance and classification
// Tracks min/max and sample count; decides calibration end; fills job queue.
// ----------------------------------------------------------------------------
module mch_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mch_pkg::in_item_t in_data,
  input  wire logic [2:0]        gain_code,
  input  wire logic [15:0]       calib_samples,
  output logic                   job_valid,
  input  wire logic              job_take,
  output mch_pkg::job_t          job,
  output logic signed [15:0]     mn [3],
  output logic signed [15:0]     mx [3]
);
  import mch_pkg::*;

  logic        calibrated;
  logic [15:0] samples_seen;
  // two-entry queue
  job_t        q [2];
  job_t        in_job;
  logic        q_wr, q_rd;
  logic        wr_head;
  logic [1:0]  q_cnt;
  logic        accept;
  logic [15:0] seen_next, limit;
  logic signed [15:0] r [3];

  assign in_stall  = (q_cnt == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign job_valid = (q_cnt != 2'd0);
  assign job       = q[0];
  assign q_rd      = job_take && job_valid;
  assign seen_next = (samples_seen == 16'hFFFF) ? samples_seen : samples_seen + 16'd1;
  assign limit     = (calib_samples == 16'd0) ? 16'd1 : calib_samples;
  assign r[0] = in_data.raw_x;
  assign r[1] = in_data.raw_y;
  assign r[2] = in_data.raw_z;
  assign q_wr = accept && (calibrated || seen_next >= limit);
  // new job lands in the head slot when the queue is empty after this edge's read
  assign wr_head = (q_cnt == 2'd0) || (q_cnt == 2'd1 && q_rd);
  assign in_job  = '{calib: !calibrated, raw_x: in_data.raw_x, raw_y: in_data.raw_y,
                     raw_z: in_data.raw_z, gain: gain_q8(gain_code)};

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated   <= 1'b0;
      samples_seen <= '0;
      q_cnt        <= '0;
      for (int a = 0; a < 3; a++) begin
        mn[a] <= 16'sd32767;
        mx[a] <= -16'sd32767;
      end
    end else begin
      if (accept && !calibrated) begin
        samples_seen <= seen_next;
        for (int a = 0; a < 3; a++) begin
          if (r[a] > mx[a]) mx[a] <= r[a];
          if (r[a] < mn[a]) mn[a] <= r[a];
        end
        if (seen_next >= limit) calibrated <= 1'b1;
      end
      q_cnt <= q_cnt + {1'b0, q_wr} - {1'b0, q_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr && wr_head) q[0] <= in_job;
    else if (q_rd)       q[0] <= q[1];
    if (q_wr && !wr_head) q[1] <= in_job;
  end
endmodule
`default_nettype wire

// File: hw/rtl/mch_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mch_back: calibration math and corrected measurement with heading
// Shared restoring divider for scales, per-axis multiply, serial CORDIC.
// ----------------------------------------------------------------------------
module mch_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_take,
  input  wire mch_pkg::job_t     job,
  input  wire logic signed [15:0] mn [3],
  input  wire logic signed [15:0] mx [3],
  input  wire logic signed [15:0] declination_centideg,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mch_pkg::out_item_t     out_data
);
  import mch_pkg::*;

  bk_state_t st, st_next;
  job_t      cur;
  logic [1:0] ax;
  logic [5:0] bit_i;
  logic [IterW-1:0] it;

  logic signed [19:0] hoff [3];
  logic [15:0]        scl  [3];
  logic               degen;
  logic [16:0]        rng  [3];
  logic [17:0]        sum;

  // divider: q = (sum*32768 + 3r) / (6r), 33 quotient bits
  logic [32:0] dnum;
  logic [18:0] drem;
  logic [32:0] dquo;
  logic [18:0] dden;
  logic [20:0] trial;

  logic signed [15:0] rawsel;
  logic signed [28:0] mulraw;
  logic signed [28:0] dprod;       // raw*gain - off*256
  logic signed [45:0] mprod;
  logic signed [45:0] rnd;
  logic signed [19:0] fld [3];

  logic signed [45:0] cx, cy, sx, sy;
  logic signed [31:0] cz, at;
  logic signed [31:0] cd;
  logic signed [31:0] tot;

  logic signed [16:0] s2;
  logic signed [28:0] s2g;
  logic signed [28:0] hsum;

  always_ff @(posedge clk) begin
    if (rst) st <= BK_IDLE;
    else     st <= st_next;
  end

  always_comb begin
    st_next  = st;
    job_take = 1'b0;
    case (st)
      BK_IDLE: if (job_valid) begin
        job_take = 1'b1;
        st_next  = job.calib ? BK_CAL_SUM : BK_MUL1;
      end
      BK_CAL_SUM:  st_next = BK_CAL_TOT;
      BK_CAL_TOT:  st_next = BK_CAL_SET;
      BK_CAL_SET:  st_next = BK_CAL_DIV;
      BK_CAL_DIV:  if (bit_i == 6'd32) st_next = BK_CAL_SCL;
      BK_CAL_SCL:  st_next = (ax == 2'd2) ? BK_CAL_DONE : BK_CAL_SET;
      BK_CAL_DONE: st_next = BK_OUT;
      BK_MUL1:     st_next = BK_MUL2;
      BK_MUL2:     st_next = BK_SAT;
      BK_SAT:      st_next = (ax == 2'd2) ? BK_VEC_INIT : BK_MUL1;
      // zero x/y vector: angle is zero, no rotation
      BK_VEC_INIT: st_next = (fld[0] == 20'sd0 && fld[1] == 20'sd0) ? BK_HDG : BK_CORDIC;
      BK_CORDIC:   if (it == IterW'(AngleIterations - 1)) st_next = BK_HDG;
      BK_HDG:      st_next = BK_MOD;
      BK_MOD:      if (!tot[31] && tot < 32'sd36000) st_next = BK_OUT;
      BK_OUT:      if (!out_stall) st_next = BK_IDLE;
      default:     st_next = BK_IDLE;
    endcase
  end

  assign out_valid = (st == BK_OUT);
  assign rawsel = (ax == 2'd0) ? cur.raw_x : (ax == 2'd1) ? cur.raw_y : cur.raw_z;
  assign mulraw = 29'(rawsel) * $signed({1'b0, cur.gain});
  assign s2    = 17'(mx[ax]) + 17'(mn[ax]);
  assign s2g   = 29'(s2) * $signed({1'b0, cur.gain});
  assign hsum  = (s2g + 29'sd256) >>> 9;
  assign trial = {1'b0, drem, dnum[32]} - {2'b00, dden};
  assign rnd   = (mprod + 46'sd2097152) >>> 22;
  assign sx    = cy >>> it;
  assign sy    = cx >>> it;
  assign at    = $signed({3'b000, atan_tab(it)});
  assign cd    = (cz + 32'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      degen <= 1'b0;
    end else if (st == BK_CAL_SCL && rng[ax] == 17'd0) begin
      degen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      BK_IDLE: begin
        cur <= job;
        ax  <= '0;
      end
      BK_CAL_SUM: begin
        for (int a = 0; a < 3; a++)
          rng[a] <= (mx[a] < mn[a]) ? 17'd0 : 17'(18'(mx[a]) - 18'(mn[a]));
      end
      BK_CAL_TOT: begin
        sum <= 18'(rng[0]) + 18'(rng[1]) + 18'(rng[2]);
      end
      BK_CAL_SET: begin
        if (hsum > 29'sd524287)       hoff[ax] <= 20'sd524287;
        else if (hsum < -29'sd524288) hoff[ax] <= -20'sd524288;
        else                          hoff[ax] <= hsum[19:0];
        dnum  <= {sum, 15'd0} + 33'(rng[ax]) * 33'd3;
        dden  <= 19'(rng[ax]) * 19'd6;
        drem  <= '0;
        dquo  <= '0;
        bit_i <= '0;
      end
      BK_CAL_DIV: begin
        if (!trial[20]) begin
          drem <= trial[18:0];
          dquo <= {dquo[31:0], 1'b1};
        end else begin
          drem <= {drem[17:0], dnum[32]};
          dquo <= {dquo[31:0], 1'b0};
        end
        dnum  <= {dnum[31:0], 1'b0};
        bit_i <= bit_i + 6'd1;
      end
      BK_CAL_SCL: begin
        if (rng[ax] == 17'd0)          scl[ax] <= 16'd16384;
        else if (dquo[32:16] != 17'd0) scl[ax] <= 16'hFFFF;
        else                           scl[ax] <= dquo[15:0];
        ax <= ax + 2'd1;
      end
      BK_CAL_DONE: begin
        out_data <= '{kind: 1'b0, field_x: hoff[0], field_y: hoff[1], field_z: hoff[2],
                      heading_centideg: 16'd0, degenerate_axis: degen};
      end
      BK_MUL1: begin
        dprod <= mulraw - (29'(hoff[ax]) <<< 8);
      end
      BK_MUL2: begin
        mprod <= 46'(dprod) * $signed({1'b0, scl[ax]});
      end
      BK_SAT: begin
        if (rnd > 46'sd524287)       fld[ax] <= 20'sd524287;
        else if (rnd < -46'sd524288) fld[ax] <= -20'sd524288;
        else                         fld[ax] <= rnd[19:0];
        ax <= ax + 2'd1;
      end
      BK_VEC_INIT: begin
        // left half plane turned by 180 degrees
        cx <= (fld[0][19] ? -46'(fld[0]) : 46'(fld[0])) <<< 24;
        cy <= (fld[0][19] ? -46'(fld[1]) : 46'(fld[1])) <<< 24;
        cz <= fld[0][19] ? 32'sd1179648000 : 32'sd0;
        it <= '0;
      end
      BK_CORDIC: begin
        if (!cy[45]) begin
          cx <= cx + sx;
          cy <= cy - sy;
          cz <= cz + at;
        end else begin
          cx <= cx - sx;
          cy <= cy + sy;
          cz <= cz - at;
        end
        it <= it + IterW'(1);
      end
      BK_HDG: begin
        tot <= cd + 32'(declination_centideg);
      end
      BK_MOD: begin
        if (tot[31])                tot <= tot + 32'sd36000;
        else if (tot >= 32'sd36000) tot <= tot - 32'sd36000;
        else
          out_data <= '{kind: 1'b1, field_x: fld[0], field_y: fld[1], field_z: fld[2],
                        heading_centideg: tot[15:0], degenerate_axis: degen};
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
